>>> design/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset
`define BPO_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bpo check failed");

// Next-cycle implication, checked out of reset
`define BPO_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bpo check failed");

`endif

>>> design/bpo_pkg.sv
package bpo_pkg;

  localparam int FRAC_BITS = 16;
  localparam int WORD_W    = 32;

  typedef logic signed [WORD_W-1:0] word_t;
  typedef logic [21:0] coef_t;

  localparam word_t WMAX = 32'sh7FFF_FFFF;
  localparam word_t WMIN = 32'sh8000_0000;

  // Q16.16 coefficients, rounded to nearest
  localparam coef_t C_A01  = 22'd1311;
  localparam coef_t C_BPOS = 22'd92;
  localparam coef_t C_BVEL = 22'd9184;
  localparam coef_t C_KX   = 22'd7864;
  localparam coef_t C_KY   = 22'd6554;
  localparam coef_t C_KC   = 22'd1311;
  localparam coef_t C_G00  = 22'd47;
  localparam coef_t C_G01  = 22'd38;
  localparam coef_t C_G12  = 22'd33;
  localparam coef_t C_G13  = 22'd41;
  localparam coef_t C_DEG  = 22'd3754936;

  // ceil(2^32 / 3492) and ceil(2^32 / 2850): exact quotients for 20-bit numerators
  localparam coef_t C_MAPX = 22'd1229945;
  localparam coef_t C_MAPY = 22'd1507007;

  localparam word_t Q_45 = 32'sd2949120;
  localparam word_t Q_38 = 32'sd2490368;
  localparam word_t Q_57 = 32'sd3735552;
  localparam word_t Q_34 = 32'sd2228224;
  localparam word_t Q_51 = 32'sd3342336;

  // Register indexes
  localparam logic [1:0] REG_TARGET_X = 2'd0;
  localparam logic [1:0] REG_TARGET_Y = 2'd1;
  localparam logic [1:0] REG_TRIM_X   = 2'd2;
  localparam logic [1:0] REG_TRIM_Y   = 2'd3;

  function automatic word_t sat33(input logic signed [32:0] v);
    word_t r;
    if (v[32] != v[31]) r = v[32] ? WMIN : WMAX;
    else r = v[31:0];
    return r;
  endfunction

  function automatic word_t sadd(input word_t a, input word_t b);
    return sat33({a[31], a} + {b[31], b});
  endfunction

  function automatic word_t ssub(input word_t a, input word_t b);
    return sat33({a[31], a} - {b[31], b});
  endfunction

  function automatic word_t negsat(input word_t a);
    return (a == WMIN) ? WMAX : -a;
  endfunction

  // Apply sign to a magnitude, saturating to the word
  function automatic word_t mag_to_word(input logic [43:0] m, input logic neg);
    word_t r;
    if (m[43:31] != '0) r = neg ? WMIN : WMAX;
    else if (neg) r = -$signed({1'b0, m[30:0]});
    else r = $signed({1'b0, m[30:0]});
    return r;
  endfunction

  function automatic word_t clampq(input word_t v, input word_t lo, input word_t hi);
    word_t r;
    if (v < lo) r = lo;
    else if (v > hi) r = hi;
    else r = v;
    return r;
  endfunction

  function automatic logic [5:0] to_deg(input word_t v);
    logic [5:0] r;
    if (v[31]) r = 6'd0;
    else if (v[30:16] > 15'd63) r = 6'd63;
    else r = v[21:16];
    return r;
  endfunction

endpackage

>>> design/bpo_if.sv
interface bpo_in_if;
  logic               valid;
  logic               ready;
  logic signed [12:0] touch_raw_x;
  logic signed [12:0] touch_raw_y;
  logic [19:0]        elapsed_us;

  modport source (output valid, touch_raw_x, touch_raw_y, elapsed_us, input ready);
  modport sink   (input valid, touch_raw_x, touch_raw_y, elapsed_us, output ready);
endinterface

interface bpo_out_if;
  logic              valid;
  logic              ready;
  logic [5:0]        servo_x_deg;
  logic [5:0]        servo_y_deg;
  logic signed [7:0] meas_x;
  logic signed [7:0] meas_y;
  logic              touch_held;

  modport source (output valid, servo_x_deg, servo_y_deg, meas_x, meas_y, touch_held,
                  input ready);
  modport sink   (input valid, servo_x_deg, servo_y_deg, meas_x, meas_y, touch_held,
                  output ready);
endinterface

>>> design/ball_plate_observer_state_feedback.sv
// Ball-on-plate observer and state-feedback controller. One touch item in gives one
// servo item out. A new touch item is taken only once the previous result has been
// written to the output register; a no-touch sentinel reading skips the mapping and
// holds the position. The work is done in two mapping states that map the reading
// through reciprocal products on the shared 32x22 multiplier, one bit-serial restoring
// divider that runs the two velocity divides (a load, 44 steps and a finish each), and
// 20 steps of the same multiplier for the observer, gain and degree products. A
// finished item waits in the output register while the next item is taken; a second
// finished item holds until the first is taken. The user must see that setpoints and
// trims are written over the APB port only while idle; the block does not enforce it.
`include "assert_macros.svh"

module ball_plate_observer_state_feedback (
  input  logic         clk,
  input  logic         rst,
  bpo_in_if.sink       in_item,
  bpo_out_if.source    out_item,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [3:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_MAPX = 4'd1;
  localparam logic [3:0] S_MAPY = 4'd2;
  localparam logic [3:0] S_VLDX = 4'd3;
  localparam logic [3:0] S_VELX = 4'd4;
  localparam logic [3:0] S_VELY = 4'd5;
  localparam logic [3:0] S_ERR  = 4'd6;
  localparam logic [3:0] S_OBS  = 4'd7;
  localparam logic [3:0] S_DONE = 4'd8;

  localparam logic [4:0] LAST_STEP = 5'd19;
  localparam logic [5:0] VEL_STEPS = 6'd44;
  localparam logic [19:0] US_PER_S = 20'd1000000;

  logic [3:0] state;
  logic [4:0] step;

  // configuration
  logic [23:0]        target_x;
  logic signed [24:0] target_y;
  logic signed [19:0] trim_x;
  logic signed [19:0] trim_y;
  logic               cfg_wr;

  // divider
  logic [43:0] div_rq;
  logic [20:0] div_rem;
  logic [19:0] div_den;
  logic [5:0]  div_cnt;
  logic [20:0] rem_sh;
  logic [21:0] trial;

  // item working registers
  logic [19:0]        dt;
  logic [19:0]        map_nx;
  logic [19:0]        map_ny;
  logic               held;
  logic signed [8:0]  px;
  logic signed [7:0]  py;
  logic signed [8:0]  last_x;
  logic signed [7:0]  last_y;
  logic               vneg;
  bpo_pkg::word_t     vx, vy;
  bpo_pkg::word_t     est [4];
  bpo_pkg::word_t     drive [2];
  bpo_pkg::word_t     err [4];
  bpo_pkg::word_t     acc, tmp, d0, d1, ph0, ph1;
  logic [5:0]         sx;

  // shared multiplier
  bpo_pkg::coef_t     coef;
  bpo_pkg::word_t     opnd;
  logic [31:0]        opnd_mag;
  logic [53:0]        prod;
  logic               prod_neg;
  bpo_pkg::word_t     pw;

  // input-side combinational
  logic signed [12:0] rx_c, ry_c;
  logic [11:0]        rx_off, ry_off;
  logic [19:0]        nx, ny;
  logic               held_in;
  logic signed [9:0]  dx, dy;
  logic [9:0]         dx_mag, dy_mag;
  logic [29:0]        vnum_x, vnum_y;
  bpo_pkg::word_t     vres;

  logic out_valid;
  logic [5:0] o_sx, o_sy;
  logic signed [7:0] o_mx, o_my;
  logic o_held;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_comb begin
    unique case (paddr[3:2])
      bpo_pkg::REG_TARGET_X: prdata = {8'd0, target_x};
      bpo_pkg::REG_TARGET_Y: prdata = {{7{target_y[24]}}, target_y};
      bpo_pkg::REG_TRIM_X:   prdata = {{12{trim_x[19]}}, trim_x};
      bpo_pkg::REG_TRIM_Y:   prdata = {{12{trim_y[19]}}, trim_y};
      default:               prdata = '0;
    endcase
  end

  assign in_item.ready        = (state == S_IDLE);
  assign out_item.valid       = out_valid;
  assign out_item.servo_x_deg = o_sx;
  assign out_item.servo_y_deg = o_sy;
  assign out_item.meas_x      = o_mx;
  assign out_item.meas_y      = o_my;
  assign out_item.touch_held  = o_held;

  // position mapping numerators
  always_comb begin
    held_in = (in_item.touch_raw_x == -13'sd3072) || (in_item.touch_raw_y == 13'sd1023);
    rx_c = (in_item.touch_raw_x < -13'sd3072) ? -13'sd3072 :
           (in_item.touch_raw_x > 13'sd1023) ? 13'sd1023 : in_item.touch_raw_x;
    ry_c = (in_item.touch_raw_y < -13'sd2500) ? -13'sd2500 :
           (in_item.touch_raw_y > 13'sd1023) ? 13'sd1023 : in_item.touch_raw_y;
    rx_off = 12'(rx_c + 13'sd3072);
    ry_off = 12'(ry_c + 13'sd2500);
    nx = 20'(rx_off * 8'd164);
    ny = 20'(ry_off * 7'd100);
  end

  // velocity numerators
  always_comb begin
    dx = {px[8], px} - {last_x[8], last_x};
    dy = {{2{py[7]}}, py} - {{2{last_y[7]}}, last_y};
    dx_mag = dx[9] ? 10'(-dx) : 10'(dx);
    dy_mag = dy[9] ? 10'(-dy) : 10'(dy);
    vnum_x = 30'(dx_mag * US_PER_S);
    vnum_y = 30'(dy_mag * US_PER_S);
    vres = bpo_pkg::mag_to_word(div_rq, vneg);
  end

  // one restoring step
  always_comb begin
    rem_sh = {div_rem[19:0], div_rq[43]};
    trial  = {1'b0, rem_sh} - {2'b00, div_den};
  end

  // multiplier operand schedule
  always_comb begin
    if (state == S_MAPX) begin
      coef = bpo_pkg::C_MAPX;
      opnd = {12'd0, map_nx};
    end else if (state == S_MAPY) begin
      coef = bpo_pkg::C_MAPY;
      opnd = {12'd0, map_ny};
    end else begin
      unique case (step)
        5'd0:  begin coef = bpo_pkg::C_A01;  opnd = est[1];   end
        5'd1:  begin coef = bpo_pkg::C_BPOS; opnd = drive[0]; end
        5'd2:  begin coef = bpo_pkg::C_KX;   opnd = err[0];   end
        5'd3:  begin coef = bpo_pkg::C_KC;   opnd = err[1];   end
        5'd4:  begin coef = bpo_pkg::C_BVEL; opnd = drive[0]; end
        5'd5:  begin coef = bpo_pkg::C_KX;   opnd = err[1];   end
        5'd6:  begin coef = bpo_pkg::C_A01;  opnd = est[3];   end
        5'd7:  begin coef = bpo_pkg::C_BPOS; opnd = drive[1]; end
        5'd8:  begin coef = bpo_pkg::C_KY;   opnd = err[2];   end
        5'd9:  begin coef = bpo_pkg::C_KC;   opnd = err[3];   end
        5'd10: begin coef = bpo_pkg::C_BVEL; opnd = drive[1]; end
        5'd11: begin coef = bpo_pkg::C_KY;   opnd = err[3];   end
        5'd12: begin coef = bpo_pkg::C_G00;  opnd = d0;       end
        5'd13: begin coef = bpo_pkg::C_G01;  opnd = est[1];   end
        5'd14: begin coef = bpo_pkg::C_G12;  opnd = d1;       end
        5'd15: begin coef = bpo_pkg::C_G13;  opnd = est[3];   end
        5'd16: begin coef = bpo_pkg::C_DEG;  opnd = drive[0]; end
        5'd17: begin coef = bpo_pkg::C_DEG;  opnd = drive[1]; end
        default: begin coef = '0;            opnd = '0;       end
      endcase
    end
    opnd_mag = opnd[31] ? 32'(-opnd) : 32'(opnd);
    pw = bpo_pkg::mag_to_word({6'd0, prod[53:16]}, prod_neg);
  end

  always_ff @(posedge clk) begin
    prod     <= opnd_mag * coef;
    prod_neg <= opnd[31];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      step      <= '0;
      div_cnt   <= '0;
      out_valid <= 1'b0;
      last_x    <= '0;
      last_y    <= '0;
      for (int i = 0; i < 4; i++) est[i] <= '0;
      drive[0]  <= '0;
      drive[1]  <= '0;
      target_x  <= 24'd6553600;
      target_y  <= -25'sd9830400;
      trim_x    <= -20'sd183501;
      trim_y    <= -20'sd183501;
    end else begin
      if (cfg_wr) begin
        unique case (paddr[3:2])
          bpo_pkg::REG_TARGET_X: target_x <= pwdata[23:0];
          bpo_pkg::REG_TARGET_Y: target_y <= pwdata[24:0];
          bpo_pkg::REG_TRIM_X:   trim_x   <= pwdata[19:0];
          bpo_pkg::REG_TRIM_Y:   trim_y   <= pwdata[19:0];
          default: ;
        endcase
      end

      if (div_cnt != '0) begin
        div_cnt <= div_cnt - 6'd1;
        if (!trial[21]) begin
          div_rem <= trial[20:0];
          div_rq  <= {div_rq[42:0], 1'b1};
        end else begin
          div_rem <= rem_sh;
          div_rq  <= {div_rq[42:0], 1'b0};
        end
      end

      if (out_valid && out_item.ready && state != S_DONE) out_valid <= 1'b0;

      unique case (state)
        S_IDLE: begin
          if (in_item.valid) begin
            dt     <= (in_item.elapsed_us == '0) ? 20'd1 : in_item.elapsed_us;
            held   <= held_in;
            map_nx <= nx;
            map_ny <= ny;
            if (held_in) begin
              px    <= last_x;
              py    <= last_y;
              state <= S_VLDX;
            end else begin
              state <= S_MAPX;
            end
          end
        end
        S_MAPX: begin
          state <= S_MAPY;
        end
        S_MAPY: begin
          // quotient is the product shifted down by 32
          px    <= $signed({1'b0, prod[39:32]}) - 9'sd82;
          state <= S_VLDX;
        end
        S_VLDX: begin
          if (!held) py <= $signed({1'b0, prod[38:32]}) - 8'sd50;
          div_rq  <= {vnum_x[27:0], 16'd0};
          div_rem <= '0;
          div_den <= dt;
          div_cnt <= VEL_STEPS;
          vneg    <= dx[9];
          state   <= S_VELX;
        end
        S_VELX: begin
          if (div_cnt == '0) begin
            vx      <= vres;
            div_rq  <= {vnum_y[27:0], 16'd0};
            div_rem <= '0;
            div_cnt <= VEL_STEPS;
            vneg    <= dy[9];
            state   <= S_VELY;
          end
        end
        S_VELY: begin
          if (div_cnt == '0) begin
            vy     <= vres;
            last_x <= px;
            last_y <= py;
            state  <= S_ERR;
          end
        end
        S_ERR: begin
          err[0] <= bpo_pkg::ssub({{7{px[8]}}, px, 16'd0}, est[0]);
          err[1] <= bpo_pkg::ssub(vx, est[1]);
          err[2] <= bpo_pkg::ssub({{8{py[7]}}, py, 16'd0}, est[2]);
          err[3] <= bpo_pkg::ssub(vy, est[3]);
          step   <= '0;
          state  <= S_OBS;
        end
        S_OBS: begin
          // each step consumes the product issued one step earlier
          case (step)
            5'd1:  acc    <= bpo_pkg::sadd(est[0], pw);
            5'd2:  acc    <= bpo_pkg::sadd(acc, pw);
            5'd3:  tmp    <= pw;
            5'd4:  est[0] <= bpo_pkg::sadd(acc, bpo_pkg::sadd(tmp, pw));
            5'd5: begin
              acc <= bpo_pkg::sadd(est[1], pw);
              d0  <= bpo_pkg::ssub(est[0], $signed({8'd0, target_x}));
            end
            5'd6:  est[1] <= bpo_pkg::sadd(acc, pw);
            5'd7:  acc    <= bpo_pkg::sadd(est[2], pw);
            5'd8:  acc    <= bpo_pkg::sadd(acc, pw);
            5'd9:  tmp    <= pw;
            5'd10: est[2] <= bpo_pkg::sadd(acc, bpo_pkg::sadd(tmp, pw));
            5'd11: begin
              acc <= bpo_pkg::sadd(est[3], pw);
              d1  <= bpo_pkg::ssub(est[2], {{7{target_y[24]}}, target_y});
            end
            5'd12: est[3]   <= bpo_pkg::sadd(acc, pw);
            5'd13: tmp      <= pw;
            5'd14: drive[0] <= bpo_pkg::negsat(bpo_pkg::sadd(tmp, pw));
            5'd15: tmp      <= pw;
            5'd16: drive[1] <= bpo_pkg::negsat(bpo_pkg::sadd(tmp, pw));
            5'd17: ph0 <= bpo_pkg::clampq(bpo_pkg::sadd(pw, bpo_pkg::Q_45),
                                          bpo_pkg::Q_38, bpo_pkg::Q_57);
            5'd18: begin
              ph1 <= bpo_pkg::clampq(bpo_pkg::sadd(pw, bpo_pkg::Q_45),
                                     bpo_pkg::Q_34, bpo_pkg::Q_51);
              sx  <= bpo_pkg::to_deg(bpo_pkg::ssub(ph0, {{12{trim_x[19]}}, trim_x}));
            end
            default: ;
          endcase
          if (step == LAST_STEP) state <= S_DONE;
          else step <= step + 5'd1;
        end
        S_DONE: begin
          // hold until the output register is free
          if (!out_valid || out_item.ready) begin
            o_sx      <= sx;
            o_sy      <= bpo_pkg::to_deg(bpo_pkg::ssub(ph1, {{12{trim_y[19]}}, trim_y}));
            o_mx      <= px[7:0];
            o_my      <= py;
            o_held    <= held;
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `BPO_ASSERT_NEXT(a_busy_after_accept, in_item.valid && in_item.ready, !in_item.ready)
  `BPO_ASSERT_IMPL(a_div_in_div_state, div_cnt != '0, state == S_VELX || state == S_VELY)
  `BPO_ASSERT_IMPL(a_result_from_done, $rose(out_valid), $past(state) == S_DONE)
  `BPO_ASSERT_IMPL(a_step_bound, state == S_OBS, step <= LAST_STEP)

endmodule

>>> dv/ball_plate_observer_state_feedback_tb.sv
`timescale 1ns / 100ps

module ball_plate_observer_state_feedback_tb;

  localparam longint ONE_Q = 64'sd65536;
  localparam longint W_HI  = 64'sd2147483647;
  localparam longint W_LO  = -64'sd2147483648;

  localparam longint K_A01  = (2 * ONE_Q + 50) / 100;
  localparam longint K_BPOS = (140143 * ONE_Q + 50000000) / 100000000;
  localparam longint K_BVEL = (14014286 * ONE_Q + 50000000) / 100000000;
  localparam longint K_KX   = (12 * ONE_Q + 50) / 100;
  localparam longint K_KY   = (ONE_Q + 5) / 10;
  localparam longint K_KC   = (2 * ONE_Q + 50) / 100;
  localparam longint K_G00  = (3568 * ONE_Q + 2500000) / 5000000;
  localparam longint K_G01  = (4959 * ONE_Q + 4250000) / 8500000;
  localparam longint K_G12  = (938384 * ONE_Q + 937500000) / 1875000000;
  localparam longint K_G13  = (1304217 * ONE_Q + 1031250000) / 2062500000;
  localparam longint K_DEG  = (64'sd57295779513 * ONE_Q + 500000000) / 1000000000;

  localparam int HOLD_RX = -3072;
  localparam int HOLD_RY = 1023;

  typedef struct packed {
    logic [5:0]        servo_x;
    logic [5:0]        servo_y;
    logic signed [7:0] meas_x;
    logic signed [7:0] meas_y;
    logic              held;
  } servo_cmd_t;

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  bpo_in_if  in_if ();
  bpo_out_if out_if ();

  ball_plate_observer_state_feedback u_top (
    .clk     (clk),
    .rst     (rst),
    .in_item (in_if),
    .out_item(out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // controller model state
  longint set_x, set_y, trim_x, trim_y;
  longint pos_x, pos_y;
  longint est[4];
  longint drv[2];

  servo_cmd_t cmd_q[$];
  int  err_cnt;
  bit  idle_on;
  int  holdoff_cycles;
  int  walk_x, walk_y;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic longint sat(longint v);
    if (v > W_HI) return W_HI;
    if (v < W_LO) return W_LO;
    return v;
  endfunction

  // constant times word, truncate toward zero
  function automatic longint cmul(longint c, longint a);
    bit neg;
    longint unsigned mc, ma, m, lim;
    neg = (c < 0) != (a < 0);
    mc = (c < 0) ? -c : c;
    ma = (a < 0) ? -a : a;
    m = (ma >> 16) * mc + (((ma & 64'hFFFF) * mc) >> 16);
    lim = W_HI + 1;
    if (m > lim) m = lim;
    return sat(neg ? -longint'(m) : longint'(m));
  endfunction

  function automatic longint vel(longint d, longint dt);
    return sat((d * 1000000 * ONE_Q) / dt);
  endfunction

  function automatic logic [5:0] to_servo(longint u, longint lo, longint hi, longint trim);
    longint phi;
    phi = sat(cmul(K_DEG, u) + 45 * ONE_Q);
    if (phi < lo * ONE_Q) phi = lo * ONE_Q;
    if (phi > hi * ONE_Q) phi = hi * ONE_Q;
    phi = sat(phi - trim);
    if (phi < 0) return 6'd0;
    phi = phi / ONE_Q;
    return (phi > 63) ? 6'd63 : phi[5:0];
  endfunction

  function automatic void reset_controller();
    set_x = 100 * ONE_Q;
    set_y = -150 * ONE_Q;
    trim_x = -((28 * ONE_Q + 5) / 10);
    trim_y = -((28 * ONE_Q + 5) / 10);
    pos_x = 0;
    pos_y = 0;
    for (int i = 0; i < 4; i++) est[i] = 0;
    drv[0] = 0;
    drv[1] = 0;
  endfunction

  function automatic servo_cmd_t advance_controller(logic signed [12:0] rx_in,
                                                    logic signed [12:0] ry_in,
                                                    logic [19:0] dt_in);
    servo_cmd_t r;
    longint rx, ry, dt, px, py, vx, vy;
    longint y[4], e[4], n[4];
    bit held;
    rx = longint'(rx_in);
    ry = longint'(ry_in);
    dt = longint'({44'd0, dt_in});
    held = (rx == HOLD_RX) || (ry == HOLD_RY);
    if (dt == 0) dt = 1;
    if (held) begin
      px = pos_x;
      py = pos_y;
    end else begin
      if (rx < -3072) rx = -3072;
      if (rx > 1023) rx = 1023;
      if (ry < -2500) ry = -2500;
      if (ry > 1023) ry = 1023;
      px = (rx + 3072) * 164 / 3492 - 82;
      py = (ry + 2500) * 100 / 2850 - 50;
    end
    vx = vel(px - pos_x, dt);
    vy = vel(py - pos_y, dt);
    pos_x = px;
    pos_y = py;
    y[0] = sat(px * ONE_Q);
    y[1] = vx;
    y[2] = sat(py * ONE_Q);
    y[3] = vy;
    for (int i = 0; i < 4; i++) e[i] = sat(y[i] - est[i]);
    n[0] = sat(sat(sat(est[0] + cmul(K_A01, est[1])) + cmul(K_BPOS, drv[0]))
               + sat(cmul(K_KX, e[0]) + cmul(K_KC, e[1])));
    n[1] = sat(sat(est[1] + cmul(K_BVEL, drv[0])) + cmul(K_KX, e[1]));
    n[2] = sat(sat(sat(est[2] + cmul(K_A01, est[3])) + cmul(K_BPOS, drv[1]))
               + sat(cmul(K_KY, e[2]) + cmul(K_KC, e[3])));
    n[3] = sat(sat(est[3] + cmul(K_BVEL, drv[1])) + cmul(K_KY, e[3]));
    for (int i = 0; i < 4; i++) est[i] = n[i];
    drv[0] = sat(-sat(cmul(K_G00, sat(n[0] - set_x)) + cmul(K_G01, n[1])));
    drv[1] = sat(-sat(cmul(K_G12, sat(n[2] - set_y)) + cmul(K_G13, n[3])));
    r.servo_x = to_servo(drv[0], 38, 57, trim_x);
    r.servo_y = to_servo(drv[1], 34, 51, trim_y);
    r.meas_x = px[7:0];
    r.meas_y = py[7:0];
    r.held = held;
    return r;
  endfunction

  // receiver: long hold-off on request, else random stall bursts while idle_on is set
  initial begin
    int stall_left;
    stall_left = 0;
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (holdoff_cycles > 0) begin
        out_if.ready <= 1'b0;
        holdoff_cycles--;
      end else if (stall_left > 0) begin
        out_if.ready <= 1'b0;
        stall_left--;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        out_if.ready <= 1'b0;
        stall_left = $urandom_range(0, 8);
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    servo_cmd_t exp_c, got;
    if (!rst && out_if.valid && out_if.ready) begin
      got = '{out_if.servo_x_deg, out_if.servo_y_deg, out_if.meas_x, out_if.meas_y,
              out_if.touch_held};
      if (cmd_q.size() == 0) begin
        err_cnt++;
        if (err_cnt <= 10) $display("unexpected servo item: %p", got);
      end else begin
        exp_c = cmd_q.pop_front();
        if (got !== exp_c) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display("servo mismatch at %0t: expected %p, actual %p", $realtime, exp_c, got);
        end
      end
    end
  end

  // called at a falling edge; returns at a falling edge with valid still high
  task automatic send_touch(int rx, int ry, int dt);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk);
    end
    in_if.valid       <= 1'b1;
    in_if.touch_raw_x <= rx[12:0];
    in_if.touch_raw_y <= ry[12:0];
    in_if.elapsed_us  <= dt[19:0];
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    cmd_q.push_back(advance_controller(rx[12:0], ry[12:0], dt[19:0]));
    @(negedge clk);
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    wait (cmd_q.size() == 0);
    repeat (200) @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    case (idx)
      bpo_pkg::REG_TARGET_X: set_x = longint'({40'd0, val[23:0]});
      bpo_pkg::REG_TARGET_Y: set_y = longint'($signed(val[24:0]));
      bpo_pkg::REG_TRIM_X:   trim_x = longint'($signed(val[19:0]));
      bpo_pkg::REG_TRIM_Y:   trim_y = longint'($signed(val[19:0]));
    endcase
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic write_all(int tx, int ty, int mx, int my);
    write_reg(bpo_pkg::REG_TARGET_X, tx);
    write_reg(bpo_pkg::REG_TARGET_Y, ty);
    write_reg(bpo_pkg::REG_TRIM_X, mx);
    write_reg(bpo_pkg::REG_TRIM_Y, my);
  endtask

  // mostly a ball drifting on the plate, some lost touches and raw noise
  task automatic send_random_touch();
    int sel, rx, ry, dt;
    sel = $urandom_range(0, 99);
    walk_x += $urandom_range(0, 120) - 60;
    walk_y += $urandom_range(0, 120) - 60;
    if (walk_x < -3000) walk_x = -3000;
    if (walk_x > 1023) walk_x = 1023;
    if (walk_y < -2500) walk_y = -2500;
    if (walk_y > 1000) walk_y = 1000;
    rx = walk_x;
    ry = walk_y;
    if (sel < 8) rx = HOLD_RX;
    else if (sel < 14) ry = HOLD_RY;
    else if (sel < 22) begin
      rx = $urandom_range(0, 4095) - 3072;
      ry = $urandom_range(0, 3523) - 2500;
    end else if (sel < 27) begin
      rx = $signed(13'($urandom()));
      ry = $signed(13'($urandom()));
    end
    sel = $urandom_range(0, 19);
    if (sel == 0) dt = $urandom_range(0, 3);
    else if (sel < 3) dt = $urandom_range(0, 20'hFFFFF);
    else dt = $urandom_range(5000, 20000);
    send_touch(rx, ry, dt);
  endtask

  task automatic test_directed_corners();
    send_touch(0, 0, 10000);
    send_touch(1023, 1023 - 1, 10000);
    send_touch(-3071, -2500, 10000);
    send_touch(HOLD_RX, 0, 10000);
    send_touch(500, HOLD_RY, 10000);
    send_touch(HOLD_RX, HOLD_RY, 0);
    send_touch(-4096, -4096, 1);
    send_touch(4095, 4095, 1);
    send_touch(1023, -2500, 0);
    send_touch(-3071, 1022, 20'hFFFFF);
    send_touch(-3073, -2501, 1);
    send_touch(1024, 1024, 20'h80000);
    send_touch(HOLD_RX, -4096, 20'hFFFFF);
    send_touch(-1, -1, 20'h55555);
    send_touch(-2731, 682, 20'hAAAAA);
    send_touch(0, 0, 1);
    drain();
  endtask

  task automatic test_setting_extremes();
    write_all(0, -11796480, -327680, -327680);
    repeat (100) send_random_touch();
    drain();
    write_all(10813440, -6553600, 327680, 327680);
    repeat (100) send_random_touch();
    drain();
    write_all($urandom_range(0, 10813440), -$urandom_range(6553600, 11796480),
              $urandom_range(0, 655360) - 327680, $urandom_range(0, 655360) - 327680);
    repeat (100) send_random_touch();
    drain();
  endtask

  task automatic test_output_backpressure();
    holdoff_cycles = 3000;
    repeat (60) send_random_touch();
    drain();
  endtask

  task automatic test_random_flight();
    write_all(6553600, -9830400, -183501, -183501);
    repeat (950) send_random_touch();
    drain();
  endtask

  task automatic test_back_to_back();
    idle_on = 1'b0;
    repeat (150) send_random_touch();
    drain();
  endtask

  initial begin
    err_cnt = 0;
    idle_on = 1'b1;
    holdoff_cycles = 0;
    walk_x = -1000;
    walk_y = -700;
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_if.valid = 1'b0;
    in_if.touch_raw_x = '0;
    in_if.touch_raw_y = '0;
    in_if.elapsed_us = '0;
    reset_controller();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_directed_corners();
    test_setting_extremes();
    test_output_backpressure();
    test_random_flight();
    test_back_to_back();
    if (cmd_q.size() != 0) err_cnt++;
    if (err_cnt == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #15_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
